FILE: sv/wbs_pkg.sv
package wbs_pkg;

    // item field widths
    localparam int REQ_W     = 2;
    localparam int WEIGHT_W  = 16;
    localparam int MAG_W     = WEIGHT_W - 1;
    localparam int UNIFORM_W = 16;
    localparam int BIN_W     = 6;

    // default table size and command queue depth
    localparam int MAX_BINS_DEF = 64;
    localparam int CMD_DEPTH    = 4;

    // result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_START  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_DRAW   = 2'd2,
        REQ_RSVD   = 2'd3
    } req_code_t;

    // decoded command handed from the front end to the back end
    typedef struct packed {
        req_code_t              kind;
        logic [MAG_W-1:0]       weight;
        logic [UNIFORM_W-1:0]   uniform;
    } cmd_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_CMP  = 2'd2
    } back_state_t;

endpackage

FILE: sv/weighted_bin_sampler_top.sv
// load items: taken from the command queue and, while the table has room, written to it in the same cycle
// draw items over n bins: empty goes low once the binary search over the sum memory ends
// (one read and one compare per step) and the result register is loaded
// a draw on an empty table gives its result without a search; up to 4 items queue up
// reset (rst_n, asynchronous) empties the queue, the table count and the result register;
// the sum memory is not cleared, only entries below the count are ever read
module weighted_bin_sampler_top #(
    parameter int MAX_BINS = wbs_pkg::MAX_BINS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [wbs_pkg::REQ_W-1:0]           req_type,
    input  logic signed [wbs_pkg::WEIGHT_W-1:0] weight,
    input  logic [wbs_pkg::UNIFORM_W-1:0]       uniform,
    output logic                                empty,
    input  logic                                pop,
    output logic [wbs_pkg::BIN_W-1:0]           bin_index,
    output logic                                status
);
    import wbs_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    // front end: decode, clamp and queue items
    wbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .weight    (weight),
        .uniform   (uniform),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // back end: table update, search and result register
    wbs_back #(
        .MAX_BINS (MAX_BINS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .bin_index (bin_index),
        .status    (status)
    );

endmodule

FILE: sv/wbs_ram.sv
module wbs_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/wbs_front.sv
module wbs_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [wbs_pkg::REQ_W-1:0]      req_type,
    input  logic signed [wbs_pkg::WEIGHT_W-1:0] weight,
    input  logic [wbs_pkg::UNIFORM_W-1:0]  uniform,
    output logic                           cmd_valid,
    output wbs_pkg::cmd_t                  cmd,
    input  logic                           cmd_take
);
    import wbs_pkg::*;

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    cmd_t             q_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    cmd_t             in_cmd;
    logic             in_en;

    // decode and clamp: negative weights count as zero, reserved codes are dropped
    always_comb
    begin
        in_cmd.kind    = req_code_t'(req_type);
        in_cmd.weight  = weight[WEIGHT_W-1] ? '0 : weight[MAG_W-1:0];
        in_cmd.uniform = uniform;
    end

    assign full  = (cnt_reg == CNT_W'(CMD_DEPTH));
    assign in_en = push && !full && (req_type != REQ_RSVD);

    // queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (in_en)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (cmd_take)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (in_en && !cmd_take)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (!in_en && cmd_take)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (in_en)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CMD_DEPTH))
        else $error("command queue over-filled");

    assert property (@(posedge clk) disable iff (!rst_n)
        PTR_W'(wr_ptr_reg - rd_ptr_reg) == cnt_reg[PTR_W-1:0])
        else $error("queue pointers disagree with fill level");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && !full && (req_type == REQ_RSVD) && !cmd_take
        |=> cnt_reg == $past(cnt_reg))
        else $error("reserved request code entered the queue");

endmodule

FILE: sv/wbs_back.sv
module wbs_back #(
    parameter int MAX_BINS = wbs_pkg::MAX_BINS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    input  wbs_pkg::cmd_t              cmd,
    output logic                       cmd_take,
    output logic                       empty,
    input  logic                       pop,
    output logic [wbs_pkg::BIN_W-1:0]  bin_index,
    output logic                       status
);
    import wbs_pkg::*;

    localparam int AW    = $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int CUM_W = MAG_W + AW;
    localparam int XW    = UNIFORM_W + CUM_W;

    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CUM_W-1:0] total_reg, total_next;
    logic [XW-1:0]    x_reg, x_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic             res_valid_reg, res_valid_next;
    logic [BIN_W-1:0] res_bin_reg, res_bin_next;
    logic             res_status_reg, res_status_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [CUM_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [CUM_W-1:0] ram_rdata;

    logic             out_free;
    logic             res_load;
    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid;
    logic             hit;
    logic [AW-1:0]    answer;
    logic [BIN_W+AW-1:0] answer_ext;
    logic [CUM_W-1:0] w_ext;

    // cumulative sum table
    wbs_ram #(
        .WIDTH (CUM_W),
        .DEPTH (MAX_BINS)
    ) u_cum_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !res_valid_reg || pop;
    assign w_ext    = CUM_W'(cmd.weight);

    // binary search probe and predicate: first bin whose scaled sum is nonzero and reaches u*total
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign hit     = ({ram_rdata, UNIFORM_W'(0)} >= x_reg) && (ram_rdata != '0);

    // search falling off the end means no positive weight: bin 0
    assign answer     = (lo_reg == count_reg) ? '0 : lo_reg[AW-1:0];
    assign answer_ext = {{BIN_W{1'b0}}, answer};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && (cmd.kind == REQ_DRAW) && (count_reg != '0))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = ST_CMP;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CMP:
            begin
                state_next = ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cmd_take  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = total_reg + w_ext;
        ram_raddr = mid[AW-1:0];
        res_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        REQ_START:
                        begin
                            cmd_take  = 1'b1;
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = w_ext;
                        end
                        REQ_APPEND:
                        begin
                            cmd_take = 1'b1;
                            if (count_reg == '0)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = w_ext;
                            end
                            else if (count_reg < CNT_W'(MAX_BINS))
                            begin
                                ram_we = 1'b1;
                            end
                        end
                        REQ_DRAW:
                        begin
                            if (count_reg != '0)
                            begin
                                cmd_take = 1'b1;
                            end
                            else if (out_free)
                            begin
                                cmd_take = 1'b1;
                                res_load = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd_take = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (!(lo_reg < hi_reg) && out_free)
                begin
                    res_load = 1'b1;
                end
            end
            ST_CMP:
            begin
                res_load = 1'b0;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // table, search and result datapath
    always_comb
    begin
        count_next      = count_reg;
        total_next      = total_reg;
        x_next          = x_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_valid_next  = res_valid_reg;
        res_bin_next    = res_bin_reg;
        res_status_next = res_status_reg;

        if (ram_we)
        begin
            total_next = ram_wdata;
            count_next = CNT_W'(ram_waddr) + CNT_W'(1);
        end

        if ((state_reg == ST_IDLE) && (state_next == ST_READ))
        begin
            x_next  = XW'(cmd.uniform) * XW'(total_reg);
            lo_next = '0;
            hi_next = count_reg;
        end

        if (state_reg == ST_CMP)
        begin
            if (hit)
            begin
                hi_next = mid;
            end
            else
            begin
                lo_next = mid + CNT_W'(1);
            end
        end

        if (res_load)
        begin
            res_valid_next = 1'b1;
            if (state_reg == ST_IDLE)
            begin
                res_bin_next    = '0;
                res_status_next = STATUS_EMPTY;
            end
            else
            begin
                res_bin_next    = answer_ext[BIN_W-1:0];
                res_status_next = STATUS_OK;
            end
        end
        else if (pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_bin_reg    <= res_bin_next;
        res_status_reg <= res_status_next;
    end

    assign empty     = !res_valid_reg;
    assign bin_index = res_bin_reg;
    assign status    = res_status_reg;

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BINS))
        else $error("bin count above table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_CMP)
        |-> (lo_reg <= hi_reg) && (hi_reg <= count_reg))
        else $error("search bounds out of order");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !pop |=> res_valid_reg && $stable(res_bin_reg)
        && $stable(res_status_reg))
        else $error("waiting result overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_status_reg == STATUS_EMPTY) |-> (res_bin_reg == '0))
        else $error("empty-table result carries a bin");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("command taken from an empty queue");

endmodule
